// ----- rtl/wpu_pkg.sv -----
// Shared types, widths and codes for the window point unprojection block.
package wpu_pkg;

   // field widths
   localparam int COORD_W  = 24;               // Q16.8 window / Q8.16 clip values
   localparam int ELEM_W   = 32;               // Q16.16 matrix elements and world values
   localparam int PROD_W   = 56;               // one element times one vector entry
   localparam int SUM_W    = 58;               // exact Q.32 row sum
   localparam int ACC_W    = SUM_W - 16;       // row sum floored to Q.16
   localparam int CFG_IDX_W = 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ELEM_W-1:0]  elem_type;
   typedef logic signed [ACC_W-1:0]   acc_type;

   // operation codes
   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_UNPROJECT = 1'b1;

   // matrix select codes
   localparam logic MAT_WINDOW_TO_VIEW = 1'b0;
   localparam logic MAT_VIEW_TO_WORLD  = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_ZERO_W = 2'd1;
   localparam logic [1:0] STATUS_SAT    = 2'd2;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_LEFT   = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_BOTTOM = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 2'd2;
   localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 2'd3;

   // one accepted beat, load fields included
   typedef struct packed {
      logic        op;
      logic        sel;
      logic [3:0]  index;
      logic [ELEM_W-1:0] value;
   } cmd_type;

endpackage

// ----- rtl/wpu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
module wpu_div #(
   parameter int LANES  = 3,
   parameter int NUM_W  = 58,
   parameter int DEN_W  = 42,
   parameter int QUO_W  = 24,
   parameter int SIDE_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]   in_num,
   input  logic [LANES-1:0][DEN_W-1:0]   in_den,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [LANES-1:0][QUO_W-1:0]   out_quo,
   output logic [LANES-1:0]              out_ovf,
   output logic [SIDE_W-1:0]             out_side
);
   localparam int HI_W   = NUM_W - QUO_W;
   localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
   localparam int STAGES = QUO_W + 1;

   logic                        valid_ff [STAGES];
   logic [LANES-1:0][DEN_W-1:0] rem_ff   [STAGES];
   logic [LANES-1:0][QUO_W-1:0] sh_ff    [STAGES];
   logic [LANES-1:0][DEN_W-1:0] den_ff   [STAGES];
   logic [LANES-1:0]            ovf_ff   [STAGES];
   logic [SIDE_W-1:0]           side_ff  [STAGES];

   logic [LANES-1:0][DEN_W-1:0] rem_in;
   logic [LANES-1:0]            ovf_in;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < STAGES; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   // entry: quotient too large for QUO_W bits, and the starting remainder
   always_comb begin
      logic [CMP_W-1:0] hi;
      for (int l = 0; l < LANES; l++) begin
         hi        = CMP_W'(in_num[l][NUM_W-1:QUO_W]);
         ovf_in[l] = hi >= CMP_W'(in_den[l]);
         rem_in[l] = hi[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= rem_in;
         ovf_ff[0]  <= ovf_in;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int l = 0; l < LANES; l++) sh_ff[0][l] <= in_num[l][QUO_W-1:0];
      end
   end

   // one restoring step per stage
   for (genvar k = 1; k < STAGES; k++) begin : g_step
      logic [LANES-1:0][DEN_W-1:0] step_rem_in;
      logic [LANES-1:0][QUO_W-1:0] step_sh_in;

      always_comb begin
         logic [DEN_W:0] trial;
         logic [DEN_W:0] diff;
         for (int l = 0; l < LANES; l++) begin
            trial = {rem_ff[k-1][l], sh_ff[k-1][l][QUO_W-1]};
            diff  = trial - {1'b0, den_ff[k-1][l]};
            if (trial >= {1'b0, den_ff[k-1][l]}) begin
               step_rem_in[l] = diff[DEN_W-1:0];
               step_sh_in[l]  = {sh_ff[k-1][l][QUO_W-2:0], 1'b1};
            end else begin
               step_rem_in[l] = trial[DEN_W-1:0];
               step_sh_in[l]  = {sh_ff[k-1][l][QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= step_rem_in;
            sh_ff[k]   <= step_sh_in;
            den_ff[k]  <= den_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quo   = sh_ff[STAGES-1];
   assign out_ovf   = ovf_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

// ----- rtl/wpu_mat.sv -----
// One 4x4 matrix store and a three stage matrix-vector product (w input fixed at 1.0).
module wpu_mat #(
   parameter int SIDE_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic                    wr_en,
   input  logic [3:0]              wr_index,
   input  logic [wpu_pkg::ELEM_W-1:0] wr_value,
   input  wpu_pkg::coord_type      v0,
   input  wpu_pkg::coord_type      v1,
   input  wpu_pkg::coord_type      v2,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output wpu_pkg::acc_type        out_acc [4],
   output logic [SIDE_W-1:0]       out_side
);
   import wpu_pkg::*;

   logic [ELEM_W-1:0]        store_ff [16];
   coord_type                v [3];
   logic signed [PROD_W-1:0] prod_in [16];
   logic signed [PROD_W-1:0] prod_ff [16];
   logic signed [SUM_W-1:0]  pair_in [8];
   logic signed [SUM_W-1:0]  pair_ff [8];
   acc_type                  acc_in [4];
   acc_type                  acc_ff [4];
   logic                     valid1_ff, valid2_ff, valid3_ff;
   logic [SIDE_W-1:0]        side1_ff, side2_ff, side3_ff;

   assign v[0] = v0;
   assign v[1] = v1;
   assign v[2] = v2;

   // element store, cleared at reset, written by load beats
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) store_ff[i] <= '0;
      end else if (wr_en) begin
         store_ff[wr_index] <= wr_value;
      end
   end

   // stage 1: element products; the fourth column scales 1.0
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r*4+c] = PROD_W'($signed(store_ff[r*4+c])) * PROD_W'(v[c]);
         end
         prod_in[r*4+3] = PROD_W'($signed(store_ff[r*4+3])) <<< 16;
      end
   end

   // stage 2: pairwise sums
   always_comb begin
      for (int p = 0; p < 8; p++) begin
         pair_in[p] = SUM_W'(prod_ff[2*p]) + SUM_W'(prod_ff[2*p+1]);
      end
   end

   // stage 3: row sums floored to Q.16
   always_comb begin
      logic signed [SUM_W-1:0] sum;
      for (int r = 0; r < 4; r++) begin
         sum       = pair_ff[2*r] + pair_ff[2*r+1];
         acc_in[r] = sum[SUM_W-1:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         pair_ff  <= pair_in;
         acc_ff   <= acc_in;
         side1_ff <= in_side;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = valid3_ff;
   assign out_acc   = acc_ff;
   assign out_side  = side3_ff;

endmodule

// ----- rtl/window_point_unprojection.sv -----
// Window point unprojection: one beat enters per cycle while req_stall is low. The pipe
// holds three bit-per-stage dividers (25 + 25 + 33 stages), two three stage matrix
// products and six staging registers; the whole pipe halts only while a result waits on
// rsp_stall. Load beats travel the pipe in order and write a matrix element as they pass
// that matrix's product stage, so points before a load use the old value and points after
// it the new one; loads give no result. csr_ready is always high; viewport registers take
// effect at once; the user must write them only while the block is idle (not enforced).
module window_point_unprojection (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic                            req_matrix_select,
   input  logic [3:0]                      req_element_index,
   input  logic signed [wpu_pkg::ELEM_W-1:0]  req_element_value,
   input  logic signed [wpu_pkg::COORD_W-1:0] req_window_x,
   input  logic signed [wpu_pkg::COORD_W-1:0] req_window_y,
   input  logic signed [wpu_pkg::COORD_W-1:0] req_depth,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [wpu_pkg::COORD_W-1:0] rsp_window_clip_x,
   output logic signed [wpu_pkg::COORD_W-1:0] rsp_window_clip_y,
   output logic signed [wpu_pkg::COORD_W-1:0] rsp_view_clip_x,
   output logic signed [wpu_pkg::COORD_W-1:0] rsp_view_clip_y,
   output logic signed [wpu_pkg::ELEM_W-1:0]  rsp_world_x,
   output logic signed [wpu_pkg::ELEM_W-1:0]  rsp_world_y,
   output logic signed [wpu_pkg::ELEM_W-1:0]  rsp_world_z,
   output logic signed [wpu_pkg::ELEM_W-1:0]  rsp_world_w,
   output logic [1:0]                      rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wpu_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [wpu_pkg::COORD_W-1:0]     csr_data
);
   import wpu_pkg::*;

   localparam int WIN_NUM_W = 42;          // |p - origin| * 2^17
   localparam int DIV_NUM_W = ACC_W + 16;  // |row| * 2^16
   localparam logic [COORD_W-1:0] SIZE_RESET = 24'h04_0000;
   localparam logic [COORD_W-1:0] SIZE_ONE   = 24'h00_0001;
   localparam coord_type CLIP_MAX = 24'sh7F_FFFF;
   localparam coord_type CLIP_MIN = 24'sh80_0000;
   localparam elem_type  WORLD_MAX = 32'sh7FFF_FFFF;
   localparam elem_type  WORLD_MIN = 32'sh8000_0000;
   localparam elem_type  ONE_Q16   = 32'sh0001_0000;

   typedef struct packed {
      logic      flag;
      coord_type value;
   } sat24_type;

   typedef struct packed {
      logic     flag;
      elem_type value;
   } sat32_type;

   typedef struct packed {
      cmd_type   cmd;
      coord_type depth;
      logic      neg_x;
      logic      neg_y;
   } side_a_type;

   typedef struct packed {
      cmd_type   cmd;
      coord_type cx;
      coord_type cy;
      logic      satf;
   } side_m0_type;

   typedef struct packed {
      side_m0_type base;
      logic        zero;
      logic [2:0]  neg;
   } side_p1_type;

   typedef struct packed {
      cmd_type   cmd;
      coord_type cx;
      coord_type cy;
      coord_type vx;
      coord_type vy;
      logic      satf;
      logic      zero;
   } side_m1_type;

   typedef struct packed {
      side_m1_type base;
      logic        zero;
      logic [2:0]  neg;
   } side_p2_type;

   // window clip: sign and magnitude quotient, minus 1.0, saturated
   function automatic sat24_type clip_sat(input logic neg, input logic ovf,
                                          input logic [COORD_W-1:0] mag);
      sat24_type        r;
      logic signed [25:0] qs;
      logic signed [25:0] t;
      qs = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      t  = qs - 26'sd65536;
      priority if (ovf) begin
         r.flag  = 1'b1;
         r.value = neg ? CLIP_MIN : CLIP_MAX;
      end else if (t > 26'sd8388607) begin
         r.flag  = 1'b1;
         r.value = CLIP_MAX;
      end else if (t < -26'sd8388608) begin
         r.flag  = 1'b1;
         r.value = CLIP_MIN;
      end else begin
         r.flag  = 1'b0;
         r.value = t[COORD_W-1:0];
      end
      return r;
   endfunction

   // perspective quotient saturated to 24 bits
   function automatic sat24_type view_sat(input logic neg, input logic ovf,
                                          input logic [COORD_W-1:0] mag);
      sat24_type r;
      priority if (ovf) begin
         r.flag  = 1'b1;
         r.value = neg ? CLIP_MIN : CLIP_MAX;
      end else if (!neg && mag > 24'h7F_FFFF) begin
         r.flag  = 1'b1;
         r.value = CLIP_MAX;
      end else if (neg && mag > 24'h80_0000) begin
         r.flag  = 1'b1;
         r.value = CLIP_MIN;
      end else begin
         r.flag  = 1'b0;
         r.value = neg ? -$signed(mag) : $signed(mag);
      end
      return r;
   endfunction

   // perspective quotient saturated to 32 bits
   function automatic sat32_type world_sat(input logic neg, input logic ovf,
                                           input logic [ELEM_W-1:0] mag);
      sat32_type r;
      priority if (ovf) begin
         r.flag  = 1'b1;
         r.value = neg ? WORLD_MIN : WORLD_MAX;
      end else if (!neg && mag > 32'h7FFF_FFFF) begin
         r.flag  = 1'b1;
         r.value = WORLD_MAX;
      end else if (neg && mag > 32'h8000_0000) begin
         r.flag  = 1'b1;
         r.value = WORLD_MIN;
      end else begin
         r.flag  = 1'b0;
         r.value = neg ? -$signed(mag) : $signed(mag);
      end
      return r;
   endfunction

   function automatic logic [ACC_W-1:0] acc_mag(input acc_type a);
      return a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
   endfunction

   logic advance;

   // viewport registers
   coord_type          left_ff, bottom_ff;
   logic [COORD_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         bottom_ff <= '0;
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_VIEWPORT_LEFT:   left_ff   <= csr_data;
            REG_VIEWPORT_BOTTOM: bottom_ff <= csr_data;
            REG_VIEWPORT_WIDTH:  width_ff  <= csr_data;
            REG_VIEWPORT_HEIGHT: height_ff <= csr_data;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // pipe moves unless a finished result is held back
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // input register
   logic      in_valid_ff;
   cmd_type   in_cmd_ff;
   coord_type in_x_ff, in_y_ff, in_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_cmd_ff.op    <= req_op;
         in_cmd_ff.sel   <= req_matrix_select;
         in_cmd_ff.index <= req_element_index;
         in_cmd_ff.value <= req_element_value;
         in_x_ff         <= req_window_x;
         in_y_ff         <= req_window_y;
         in_depth_ff     <= req_depth;
      end
   end

   // window numerators and sizes
   logic signed [COORD_W:0]          diff_x, diff_y;
   logic [COORD_W:0]                 mag_x, mag_y;
   logic [1:0][WIN_NUM_W-1:0]        a_num;
   logic [1:0][COORD_W-1:0]          a_den;
   side_a_type                       a_side_in;

   always_comb begin
      diff_x = {in_x_ff[COORD_W-1], in_x_ff} - {left_ff[COORD_W-1], left_ff};
      diff_y = {in_y_ff[COORD_W-1], in_y_ff} - {bottom_ff[COORD_W-1], bottom_ff};
      mag_x  = diff_x[COORD_W] ? (COORD_W+1)'(-diff_x) : (COORD_W+1)'(diff_x);
      mag_y  = diff_y[COORD_W] ? (COORD_W+1)'(-diff_y) : (COORD_W+1)'(diff_y);
      a_num[0] = {mag_x, 17'd0};
      a_num[1] = {mag_y, 17'd0};
      a_den[0] = (width_ff == '0) ? SIZE_ONE : width_ff;
      a_den[1] = (height_ff == '0) ? SIZE_ONE : height_ff;
      a_side_in.cmd   = in_cmd_ff;
      a_side_in.depth = in_depth_ff;
      a_side_in.neg_x = diff_x[COORD_W];
      a_side_in.neg_y = diff_y[COORD_W];
   end

   logic                          a_valid;
   logic [1:0][COORD_W-1:0]       a_quo;
   logic [1:0]                    a_ovf;
   logic [$bits(side_a_type)-1:0] a_side;
   side_a_type                    a_side_s;

   wpu_div #(
      .LANES(2), .NUM_W(WIN_NUM_W), .DEN_W(COORD_W), .QUO_W(COORD_W),
      .SIDE_W($bits(side_a_type))
   ) u_div_window (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(in_valid_ff),
      .in_num(a_num), .in_den(a_den), .in_side(a_side_in),
      .out_valid(a_valid), .out_quo(a_quo), .out_ovf(a_ovf), .out_side(a_side)
   );
   assign a_side_s = a_side;

   // window clip register
   sat24_type   clip_x, clip_y;
   logic        cr_valid_ff;
   side_m0_type cr_side_ff;
   coord_type   cr_depth_ff;

   assign clip_x = clip_sat(a_side_s.neg_x, a_ovf[0], a_quo[0]);
   assign clip_y = clip_sat(a_side_s.neg_y, a_ovf[1], a_quo[1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_valid_ff <= 1'b0;
      end else if (advance) begin
         cr_valid_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cr_side_ff.cmd  <= a_side_s.cmd;
         cr_side_ff.cx   <= clip_x.value;
         cr_side_ff.cy   <= clip_y.value;
         cr_side_ff.satf <= clip_x.flag | clip_y.flag;
         cr_depth_ff     <= a_side_s.depth;
      end
   end

   // first matrix product; loads to the first matrix land here
   logic                           m0_wr_en;
   logic                           m0_valid;
   acc_type                        m0_acc [4];
   logic [$bits(side_m0_type)-1:0] m0_side;
   side_m0_type                    m0_side_s;

   assign m0_wr_en = advance && cr_valid_ff && cr_side_ff.cmd.op == OP_LOAD
                     && cr_side_ff.cmd.sel == MAT_WINDOW_TO_VIEW;

   wpu_mat #(.SIDE_W($bits(side_m0_type))) u_mat_view (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(cr_valid_ff),
      .wr_en(m0_wr_en), .wr_index(cr_side_ff.cmd.index), .wr_value(cr_side_ff.cmd.value),
      .v0(cr_side_ff.cx), .v1(cr_side_ff.cy), .v2(cr_depth_ff), .in_side(cr_side_ff),
      .out_valid(m0_valid), .out_acc(m0_acc), .out_side(m0_side)
   );
   assign m0_side_s = m0_side;

   // first divide operands
   logic                        p1_valid_ff;
   logic [2:0][DIV_NUM_W-1:0]   p1_num_ff;
   logic [ACC_W-1:0]            p1_den_ff;
   side_p1_type                 p1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= m0_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            p1_num_ff[r]      <= {acc_mag(m0_acc[r]), 16'd0};
            p1_side_ff.neg[r] <= m0_acc[r][ACC_W-1] ^ m0_acc[3][ACC_W-1];
         end
         p1_den_ff       <= acc_mag(m0_acc[3]);
         p1_side_ff.zero <= m0_acc[3] == '0;
         p1_side_ff.base <= m0_side_s;
      end
   end

   logic                          b_valid;
   logic [2:0][COORD_W-1:0]       b_quo;
   logic [2:0]                    b_ovf;
   logic [$bits(side_p1_type)-1:0] b_side;
   side_p1_type                   b_side_s;

   wpu_div #(
      .LANES(3), .NUM_W(DIV_NUM_W), .DEN_W(ACC_W), .QUO_W(COORD_W),
      .SIDE_W($bits(side_p1_type))
   ) u_div_view (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(p1_valid_ff),
      .in_num(p1_num_ff), .in_den({3{p1_den_ff}}), .in_side(p1_side_ff),
      .out_valid(b_valid), .out_quo(b_quo), .out_ovf(b_ovf), .out_side(b_side)
   );
   assign b_side_s = b_side;

   // view clip register; a zero w clears the view values
   sat24_type   view_x, view_y, view_z;
   logic        vw_valid_ff;
   side_m1_type vw_side_ff;
   coord_type   vw_z_ff;

   assign view_x = view_sat(b_side_s.neg[0], b_ovf[0], b_quo[0]);
   assign view_y = view_sat(b_side_s.neg[1], b_ovf[1], b_quo[1]);
   assign view_z = view_sat(b_side_s.neg[2], b_ovf[2], b_quo[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vw_valid_ff <= 1'b0;
      end else if (advance) begin
         vw_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vw_side_ff.cmd  <= b_side_s.base.cmd;
         vw_side_ff.cx   <= b_side_s.base.cx;
         vw_side_ff.cy   <= b_side_s.base.cy;
         vw_side_ff.zero <= b_side_s.zero;
         if (b_side_s.zero) begin
            vw_side_ff.vx   <= '0;
            vw_side_ff.vy   <= '0;
            vw_z_ff         <= '0;
            vw_side_ff.satf <= b_side_s.base.satf;
         end else begin
            vw_side_ff.vx   <= view_x.value;
            vw_side_ff.vy   <= view_y.value;
            vw_z_ff         <= view_z.value;
            vw_side_ff.satf <= b_side_s.base.satf | view_x.flag | view_y.flag | view_z.flag;
         end
      end
   end

   // second matrix product; loads to the second matrix land here
   logic                           m1_wr_en;
   logic                           m1_valid;
   acc_type                        m1_acc [4];
   logic [$bits(side_m1_type)-1:0] m1_side;
   side_m1_type                    m1_side_s;

   assign m1_wr_en = advance && vw_valid_ff && vw_side_ff.cmd.op == OP_LOAD
                     && vw_side_ff.cmd.sel == MAT_VIEW_TO_WORLD;

   wpu_mat #(.SIDE_W($bits(side_m1_type))) u_mat_world (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(vw_valid_ff),
      .wr_en(m1_wr_en), .wr_index(vw_side_ff.cmd.index), .wr_value(vw_side_ff.cmd.value),
      .v0(vw_side_ff.vx), .v1(vw_side_ff.vy), .v2(vw_z_ff), .in_side(vw_side_ff),
      .out_valid(m1_valid), .out_acc(m1_acc), .out_side(m1_side)
   );
   assign m1_side_s = m1_side;

   // second divide operands
   logic                      p2_valid_ff;
   logic [2:0][DIV_NUM_W-1:0] p2_num_ff;
   logic [ACC_W-1:0]          p2_den_ff;
   side_p2_type               p2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p2_valid_ff <= m1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            p2_num_ff[r]      <= {acc_mag(m1_acc[r]), 16'd0};
            p2_side_ff.neg[r] <= m1_acc[r][ACC_W-1] ^ m1_acc[3][ACC_W-1];
         end
         p2_den_ff       <= acc_mag(m1_acc[3]);
         p2_side_ff.zero <= m1_acc[3] == '0;
         p2_side_ff.base <= m1_side_s;
      end
   end

   logic                           c_valid;
   logic [2:0][ELEM_W-1:0]         c_quo;
   logic [2:0]                     c_ovf;
   logic [$bits(side_p2_type)-1:0] c_side;
   side_p2_type                    c_side_s;

   wpu_div #(
      .LANES(3), .NUM_W(DIV_NUM_W), .DEN_W(ACC_W), .QUO_W(ELEM_W),
      .SIDE_W($bits(side_p2_type))
   ) u_div_world (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(p2_valid_ff),
      .in_num(p2_num_ff), .in_den({3{p2_den_ff}}), .in_side(p2_side_ff),
      .out_valid(c_valid), .out_quo(c_quo), .out_ovf(c_ovf), .out_side(c_side)
   );
   assign c_side_s = c_side;

   // world values and status
   sat32_type world_x, world_y, world_z;
   logic      any_zero;
   logic      any_sat;

   assign world_x  = world_sat(c_side_s.neg[0], c_ovf[0], c_quo[0]);
   assign world_y  = world_sat(c_side_s.neg[1], c_ovf[1], c_quo[1]);
   assign world_z  = world_sat(c_side_s.neg[2], c_ovf[2], c_quo[2]);
   assign any_zero = c_side_s.base.zero | c_side_s.zero;
   assign any_sat  = c_side_s.base.satf | world_x.flag | world_y.flag | world_z.flag;

   // result register; only unproject beats give a result
   logic       rsp_valid_ff;
   coord_type  rsp_window_clip_x_ff, rsp_window_clip_y_ff;
   coord_type  rsp_view_clip_x_ff, rsp_view_clip_y_ff;
   elem_type   rsp_world_x_ff, rsp_world_y_ff, rsp_world_z_ff, rsp_world_w_ff;
   logic [1:0] rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= c_valid && c_side_s.base.cmd.op == OP_UNPROJECT;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_window_clip_x_ff <= c_side_s.base.cx;
         rsp_window_clip_y_ff <= c_side_s.base.cy;
         rsp_view_clip_x_ff   <= c_side_s.base.vx;
         rsp_view_clip_y_ff   <= c_side_s.base.vy;
         if (any_zero) begin
            rsp_world_x_ff <= '0;
            rsp_world_y_ff <= '0;
            rsp_world_z_ff <= '0;
            rsp_world_w_ff <= '0;
            rsp_status_ff  <= STATUS_ZERO_W;
         end else begin
            rsp_world_x_ff <= world_x.value;
            rsp_world_y_ff <= world_y.value;
            rsp_world_z_ff <= world_z.value;
            rsp_world_w_ff <= ONE_Q16;
            rsp_status_ff  <= any_sat ? STATUS_SAT : STATUS_OK;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_window_clip_x = rsp_window_clip_x_ff;
   assign rsp_window_clip_y = rsp_window_clip_y_ff;
   assign rsp_view_clip_x   = rsp_view_clip_x_ff;
   assign rsp_view_clip_y   = rsp_view_clip_y_ff;
   assign rsp_world_x       = rsp_world_x_ff;
   assign rsp_world_y       = rsp_world_y_ff;
   assign rsp_world_z       = rsp_world_z_ff;
   assign rsp_world_w       = rsp_world_w_ff;
   assign rsp_status        = rsp_status_ff;

endmodule
